// ===== rtl/core/dosq_pkg.sv =====
// Shared codes for the dual-order service queue: request modes and result status.
// No dependencies; imported by the queue's top level and its checker.
package dosq_pkg;

   typedef logic [1:0] mode_type;
   typedef logic [1:0] status_type;

   localparam mode_type MODE_ARRIVE = 2'd0;
   localparam mode_type MODE_OLDEST = 2'd1;
   localparam mode_type MODE_BEST   = 2'd2;

   localparam status_type STATUS_SERVED   = 2'd0;
   localparam status_type STATUS_ACCEPTED = 2'd1;
   localparam status_type STATUS_EMPTY    = 2'd2;
   localparam status_type STATUS_FULL     = 2'd3;

endpackage

// ===== rtl/core/dual_order_service_queue_unit.sv =====
// Dual-order service queue top level: command sequencer around the entry store.
// Depends on dosq_pkg and dosq_store.

// Arrivals keep busy low, and the result strobe comes in the cycle after start.
// A serve raises busy and walks the entry store through its single read port,
// one entry a cycle, with one comparator: an oldest-serve reads the entries from
// the oldest pointer up to the one served (or to the end if none waits), a
// best-serve every id handed out so far. The result strobe comes in the same
// cycle that busy falls. Results cannot be held off; each shows for exactly one
// cycle. Reset needs no clearing pass: an entry counts as waiting only below the
// arrival count.
module dual_order_service_queue_unit #(
   parameter int CAPACITY   = 256,
   parameter int VALUE_BITS = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  dosq_pkg::mode_type                 req_mode,
   input  logic [VALUE_BITS-1:0]              req_value,
   output logic                               rsp_valid,
   output dosq_pkg::status_type               rsp_status,
   output logic [$clog2(CAPACITY+1)-1:0]      rsp_served_id
);

   import dosq_pkg::*;

   localparam int IDX_BITS = $clog2(CAPACITY);
   localparam int ID_BITS  = $clog2(CAPACITY + 1);
   localparam int ENT_BITS = VALUE_BITS + 1;

   typedef enum logic {ST_IDLE, ST_SCAN} state_type;

   state_type             state_ff, state_in;
   logic [ID_BITS-1:0]    fill_ff, fill_in;
   logic [ID_BITS-1:0]    oldest_ff, oldest_in;
   logic [ID_BITS-1:0]    scan_ff, scan_in;
   logic                  best_mode_ff, best_mode_in;
   logic                  pend_ff, pend_in;
   logic [IDX_BITS-1:0]   pend_idx_ff, pend_idx_in;
   logic                  best_found_ff, best_found_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   logic [VALUE_BITS-1:0] best_val_ff, best_val_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]    rsp_id_ff, rsp_id_in;

   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [ENT_BITS-1:0]   wr_data;
   logic                  rd_en;
   logic [ENT_BITS-1:0]   rd_data;

   logic                  issue;
   logic                  rd_waiting;
   logic [VALUE_BITS-1:0] rd_value;
   logic                  better;
   logic                  take;
   logic                  best_found_nx;
   logic [IDX_BITS-1:0]   best_idx_nx;
   logic                  oldest_hit;

   dosq_store #(
      .DEPTH (CAPACITY),
      .WIDTH (ENT_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   // Every entry below the arrival count has been written, so its read is defined.
   assign issue      = (scan_ff < fill_ff);
   assign rd_en      = (state_ff == ST_SCAN) && issue;
   assign rd_waiting = rd_data[VALUE_BITS];
   assign rd_value   = rd_data[VALUE_BITS-1:0];
   assign better     = (rd_value > best_val_ff);
   assign take       = pend_ff && rd_waiting && (!best_found_ff || better);
   assign best_found_nx = best_found_ff || take;
   assign best_idx_nx   = take ? pend_idx_ff : best_idx_ff;
   assign oldest_hit    = !best_mode_ff && pend_ff && rd_waiting;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      oldest_in     = oldest_ff;
      scan_in       = scan_ff;
      best_mode_in  = best_mode_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      best_found_in = best_found_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      wr_en         = 1'b0;
      wr_addr       = fill_ff[IDX_BITS-1:0];
      wr_data       = {1'b1, req_value};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               case (req_mode)
                  MODE_ARRIVE: begin
                     rsp_valid_in = 1'b1;
                     if (fill_ff == ID_BITS'(CAPACITY)) begin
                        rsp_status_in = STATUS_FULL;
                        rsp_id_in     = '0;
                     end else begin
                        wr_en         = 1'b1;
                        rsp_status_in = STATUS_ACCEPTED;
                        rsp_id_in     = ID_BITS'(fill_ff + 1'b1);
                        fill_in       = ID_BITS'(fill_ff + 1'b1);
                     end
                  end
                  MODE_OLDEST: begin
                     state_in     = ST_SCAN;
                     best_mode_in = 1'b0;
                     scan_in      = oldest_ff;
                     pend_in      = 1'b0;
                  end
                  default: begin
                     // The unused mode code serves like a best-serve.
                     state_in      = ST_SCAN;
                     best_mode_in  = 1'b1;
                     scan_in       = '0;
                     pend_in       = 1'b0;
                     best_found_in = 1'b0;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            scan_in       = issue ? ID_BITS'(scan_ff + 1'b1) : scan_ff;
            pend_in       = issue;
            pend_idx_in   = scan_ff[IDX_BITS-1:0];
            best_found_in = best_found_nx;
            best_idx_in   = best_idx_nx;
            best_val_in   = take ? rd_value : best_val_ff;
            if (oldest_hit) begin
               state_in      = ST_IDLE;
               pend_in       = 1'b0;
               wr_en         = 1'b1;
               wr_addr       = pend_idx_ff;
               wr_data       = {1'b0, rd_value};
               oldest_in     = ID_BITS'(pend_idx_ff) + ID_BITS'(1);
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_SERVED;
               rsp_id_in     = ID_BITS'(pend_idx_ff) + ID_BITS'(1);
            end else if (!issue) begin
               // Nothing left to read; the last pending entry is folded in above.
               state_in     = ST_IDLE;
               pend_in      = 1'b0;
               rsp_valid_in = 1'b1;
               if (best_mode_ff && best_found_nx) begin
                  wr_en         = 1'b1;
                  wr_addr       = best_idx_nx;
                  wr_data       = {1'b0, best_val_in};
                  rsp_status_in = STATUS_SERVED;
                  rsp_id_in     = ID_BITS'(best_idx_nx) + ID_BITS'(1);
               end else begin
                  rsp_status_in = STATUS_EMPTY;
                  rsp_id_in     = '0;
                  if (!best_mode_ff) begin
                     oldest_in = fill_ff;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         oldest_ff    <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         oldest_ff    <= oldest_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_ff       <= scan_in;
      best_mode_ff  <= best_mode_in;
      pend_idx_ff   <= pend_idx_in;
      best_found_ff <= best_found_in;
      best_idx_ff   <= best_idx_in;
      best_val_ff   <= best_val_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_served_id = rsp_id_ff;

endmodule

// ===== rtl/core/dosq_store.sv =====
// Entry store of the dual-order service queue: one write port and one read port
// with registered read data. Standalone; used by dual_order_service_queue_unit.
module dosq_store #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 21
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/dosq_checker.sv =====
// Port-level checks for the dual-order service queue, bound to its top level.
// Depends on dosq_pkg and dual_order_service_queue_unit.
module dosq_checker #(
   parameter int CAPACITY   = 256
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input dosq_pkg::mode_type            req_mode,
   input logic                          rsp_valid,
   input dosq_pkg::status_type          rsp_status,
   input logic [$clog2(CAPACITY+1)-1:0] rsp_served_id
);

   import dosq_pkg::*;

   // An arrival answers in the very next cycle.
   a_arrive_answer: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode == MODE_ARRIVE |=> rsp_valid)
      else $error("arrival item got no result in the next cycle");

   // A serve always raises busy once it is taken.
   a_serve_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode != MODE_ARRIVE |=> busy)
      else $error("serve item did not raise busy");

   // The end of a serve is always reported.
   a_serve_done: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   // An id is reported exactly when something was served or accepted.
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == STATUS_EMPTY || rsp_status == STATUS_FULL)
                     == (rsp_served_id == '0)))
      else $error("result id does not match its status");

endmodule

bind dual_order_service_queue_unit dosq_checker #(
   .CAPACITY   (CAPACITY)
) u_dosq_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_mode      (req_mode),
   .rsp_valid     (rsp_valid),
   .rsp_status    (rsp_status),
   .rsp_served_id (rsp_served_id)
);

// ===== sim/tb_dual_order_service_queue_unit.sv =====
// Self-checking bench for dual_order_service_queue_unit: arrivals, oldest-serves and best-serves.
// Keeps its own copy of the waiting store and compares every result strobe against it.
// Depends on dosq_pkg and the queue's RTL.
`timescale 1ns / 100ps

module tb_dual_order_service_queue_unit;
   import dosq_pkg::*;

   localparam int CAPACITY   = 256;
   localparam int VALUE_BITS = 20;
   localparam int ID_BITS    = $clog2(CAPACITY + 1);
   localparam int CYCLE_LIMIT = 1_500_000;
   localparam int RANDOM_ITEMS = 1400;
   // The block decodes the spare mode code as a best-serve.
   localparam mode_type MODE_SPARE = 2'd3;

   typedef struct packed {
      mode_type               mode;
      logic [VALUE_BITS-1:0]  value;
      logic                   steady;
   } request_type;

   typedef struct packed {
      status_type             status;
      logic [ID_BITS-1:0]     id;
   } outcome_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   mode_type                  req_mode = MODE_ARRIVE;
   logic [VALUE_BITS-1:0]     req_value = '0;
   logic                      rsp_valid;
   status_type                rsp_status;
   logic [ID_BITS-1:0]        rsp_served_id;

   request_type               request_backlog[$];
   outcome_type               expected_outcomes[$];

   // Shadow of the queue's store, indexed by id.
   logic [VALUE_BITS-1:0]     ticket_value[1:CAPACITY];
   logic                      ticket_waiting[1:CAPACITY];
   int unsigned               next_ticket = 1;
   int unsigned               oldest_ticket = 1;

   int unsigned               mismatches = 0;
   int unsigned               items_sent = 0;
   int unsigned               n_served = 0;
   int unsigned               n_accepted = 0;
   int unsigned               n_empty = 0;
   int unsigned               n_full = 0;
   int unsigned               cycle_count = 0;

   dual_order_service_queue_unit #(
      .CAPACITY   (CAPACITY),
      .VALUE_BITS (VALUE_BITS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_mode      (req_mode),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_served_id (rsp_served_id)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic outcome_type serve_outcome(mode_type mode, logic [VALUE_BITS-1:0] value);
      outcome_type            result;
      int unsigned            best_id;
      logic [VALUE_BITS-1:0]  best_value;
      result.status = STATUS_EMPTY;
      result.id = '0;
      best_id = 0;
      best_value = '0;
      if (mode == MODE_ARRIVE) begin
         if (next_ticket > CAPACITY) begin
            result.status = STATUS_FULL;
         end else begin
            ticket_value[next_ticket] = value;
            ticket_waiting[next_ticket] = 1'b1;
            result.status = STATUS_ACCEPTED;
            result.id = next_ticket[ID_BITS-1:0];
            next_ticket++;
         end
      end else if (mode == MODE_OLDEST) begin
         while (oldest_ticket < next_ticket && !ticket_waiting[oldest_ticket])
            oldest_ticket++;
         if (oldest_ticket < next_ticket) begin
            ticket_waiting[oldest_ticket] = 1'b0;
            result.status = STATUS_SERVED;
            result.id = oldest_ticket[ID_BITS-1:0];
            oldest_ticket++;
         end
      end else begin
         // Strictly greater keeps the smaller id on a tie.
         for (int unsigned id = 1; id < next_ticket; id++) begin
            if (ticket_waiting[id] && (best_id == 0 || ticket_value[id] > best_value)) begin
               best_id = id;
               best_value = ticket_value[id];
            end
         end
         if (best_id != 0) begin
            ticket_waiting[best_id] = 1'b0;
            result.status = STATUS_SERVED;
            result.id = best_id[ID_BITS-1:0];
         end
      end
      return result;
   endfunction

   task automatic add_request(mode_type mode, logic [VALUE_BITS-1:0] value, logic steady);
      request_type item;
      item.mode = mode;
      item.value = value;
      item.steady = steady;
      request_backlog.insert(request_backlog.size(), item);
   endtask

   // Driver: an item is taken at an edge where start is high and busy is low.
   always @(posedge clock) begin : drive_requests
      request_type item;
      logic        taken;
      if (reset) begin
         start <= 1'b0;
      end else begin
         taken = start && !busy;
         if (taken) begin
            expected_outcomes.insert(expected_outcomes.size(),
                                     serve_outcome(req_mode, req_value));
            items_sent++;
         end
         if (!start || taken) begin
            if (request_backlog.size() != 0 &&
                (request_backlog[0].steady || $urandom_range(0, 99) >= 36)) begin
               item = request_backlog[0];
               request_backlog.delete(0);
               start <= 1'b1;
               req_mode <= item.mode;
               req_value <= item.value;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_valid === 1'b1) begin
         case (rsp_status)
            STATUS_SERVED:   n_served++;
            STATUS_ACCEPTED: n_accepted++;
            STATUS_EMPTY:    n_empty++;
            STATUS_FULL:     n_full++;
            default:         ;
         endcase
         if (expected_outcomes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result status %0d id %0d with no item outstanding",
                        rsp_status, rsp_served_id);
         end else begin
            want = expected_outcomes[0];
            expected_outcomes.delete(0);
            if (rsp_status !== want.status || rsp_served_id !== want.id) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: expected status %0d id %0d, got status %0d id %0d",
                           want.status, want.id, rsp_status, rsp_served_id);
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_outcomes.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin : stimulus
      mode_type               mode;
      logic [VALUE_BITS-1:0]  value;
      logic                   filling;
      int unsigned            pick;

      // Serves of every kind on an empty store.
      add_request(MODE_OLDEST, '0, 1'b0);
      add_request(MODE_BEST, '0, 1'b0);
      add_request(MODE_SPARE, '1, 1'b0);
      // Extreme values and a tie at the top: ids 1 to 4.
      add_request(MODE_ARRIVE, '0, 1'b0);
      add_request(MODE_ARRIVE, '1, 1'b0);
      add_request(MODE_ARRIVE, '1, 1'b0);
      add_request(MODE_ARRIVE, 20'd5, 1'b0);
      add_request(MODE_BEST, '0, 1'b0);
      add_request(MODE_SPARE, '0, 1'b0);
      add_request(MODE_OLDEST, '0, 1'b0);
      add_request(MODE_OLDEST, '0, 1'b0);
      // The oldest pointer has to skip ids already taken by best-serves.
      add_request(MODE_OLDEST, '1, 1'b0);
      add_request(MODE_ARRIVE, 20'd7, 1'b0);
      add_request(MODE_ARRIVE, 20'd7, 1'b0);
      add_request(MODE_ARRIVE, '0, 1'b0);
      add_request(MODE_BEST, '0, 1'b0);
      add_request(MODE_OLDEST, '0, 1'b0);
      add_request(MODE_BEST, '0, 1'b0);
      add_request(MODE_BEST, '0, 1'b0);
      add_request(MODE_ARRIVE, 20'hAAAAA, 1'b0);
      add_request(MODE_ARRIVE, 20'h55555, 1'b0);
      add_request(MODE_OLDEST, '0, 1'b0);
      add_request(MODE_BEST, '0, 1'b0);

      // Random part in blocks that either build the store up or drain it.
      // The store runs out of ids part way through, after which arrivals are dropped.
      filling = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0)
            filling = ($urandom_range(0, 1) == 1);
         pick = $urandom_range(0, 99);
         if (pick < (filling ? 55 : 15)) begin
            mode = MODE_ARRIVE;
         end else begin
            pick = $urandom_range(0, 99);
            mode = (pick < 45) ? MODE_OLDEST : (pick < 90) ? MODE_BEST : MODE_SPARE;
         end
         case ($urandom_range(0, 9))
            6, 7:    value = VALUE_BITS'($urandom_range(0, 7));
            8:       value = '1;
            9:       value = '0;
            default: value = VALUE_BITS'($urandom());
         endcase
         add_request(mode, value, (i >= 500 && i < 700));
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (request_backlog.size() != 0 || start)
         @(posedge clock);
      while (expected_outcomes.size() != 0)
         @(posedge clock);
      repeat (CAPACITY + 4) @(posedge clock);

      $display("Ran %0d requests in %0d cycles: %0d accepted, %0d dropped as full,",
               items_sent, cycle_count, n_accepted, n_full);
      $display("%0d served in oldest or best order, %0d serves found the store empty.",
               n_served, n_empty);
      if (mismatches == 0 && expected_outcomes.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
